@@ hw/rtl/mrupr_pkg.sv @@
// Shared types and constants for the MRU page replacement block.
package mrupr_pkg;

  // Build-time defaults
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CFG_BITS   = 5;
  localparam int SLOT_BITS  = 4;
  localparam int COUNT_BITS = 32;

  // Frame count after reset
  localparam logic [CFG_BITS-1:0] FRAME_COUNT_RESET = CFG_BITS'(4);

  // Saturation value of the fault counter
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } seq_state_t;

endpackage

@@ hw/rtl/mrupr_frame_store.sv @@
// Frame page memory with registered read and per-frame valid bits.
module mrupr_frame_store #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [PAGE_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [PAGE_BITS-1:0] wr_data,
  output logic [FRAMES-1:0]    valid_bits
);
  import mrupr_pkg::*;

  logic [PAGE_BITS-1:0] mem [FRAMES];

  // Write one frame, read one frame every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Mark a frame occupied once written; reset empties all frames
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/mrupr_seq.sv @@
// Scan sequencer: walks the frames through one compare unit and applies the update.
module mrupr_seq #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [PAGE_BITS-1:0]           page,
  input  logic [CNT_W-1:0]               n,
  output logic                           busy,
  output logic [IDX_W-1:0]               rd_addr,
  input  logic [PAGE_BITS-1:0]           rd_data,
  input  logic [FRAMES-1:0]              valid_bits,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output logic [PAGE_BITS-1:0]           wr_data,
  output logic                           done,
  output logic                           fault,
  output logic [mrupr_pkg::SLOT_BITS-1:0] slot,
  output logic                           evicted_valid,
  output logic [PAGE_BITS-1:0]           evicted_page,
  output logic [mrupr_pkg::COUNT_BITS-1:0] fault_total
);
  import mrupr_pkg::*;

  seq_state_t state, state_next;

  // Captured reference
  logic [PAGE_BITS-1:0] page_q;
  logic [CNT_W-1:0]     n_q;
  logic [IDX_W-1:0]     victim_q;

  // Scan pointer and compare stage
  logic [CNT_W-1:0]     issue_idx;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  logic                 chk_fv;

  // Scan findings
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_slot;
  logic                 have_empty;
  logic [IDX_W-1:0]     empty_slot;
  logic [PAGE_BITS-1:0] ev_cap;

  // Persistent state
  logic [IDX_W-1:0]      last_slot;
  logic [COUNT_BITS-1:0] fault_counter;
  logic [COUNT_BITS-1:0] fault_counter_next;

  logic                  issue_ok;
  logic                  issue_fv;
  logic                  issue_go;
  logic                  hit_now;
  logic                  scan_end;
  logic [IDX_W-1:0]      fin_slot;
  logic [IDX_W-1:0]      n_last;
  logic [SLOT_BITS+IDX_W-1:0] slot_ext;

  // Scan control and the shared compare
  always_comb begin
    issue_ok = (issue_idx != n_q);
    issue_fv = valid_bits[issue_idx[IDX_W-1:0]];
    hit_now  = chk_vld && chk_fv && (rd_data == page_q);
    issue_go = (state == ST_SCAN) && issue_ok && !hit_now;
    scan_end = hit_now || !issue_ok;
    rd_addr  = issue_idx[IDX_W-1:0];
  end

  // Pick the frame to use and the next fault count
  always_comb begin
    if (hit_q) begin
      fin_slot = hit_slot;
    end else if (have_empty) begin
      fin_slot = empty_slot;
    end else begin
      fin_slot = victim_q;
    end
    if (!hit_q && (fault_counter != COUNT_MAX)) begin
      fault_counter_next = fault_counter + COUNT_BITS'(1);
    end else begin
      fault_counter_next = fault_counter;
    end
    wr_en    = (state == ST_FINISH) && !hit_q;
    wr_addr  = fin_slot;
    wr_data  = page_q;
    n_last   = IDX_W'(n - CNT_W'(1));
    slot_ext = (SLOT_BITS + IDX_W)'(fin_slot);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the reference and advance the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (state == ST_IDLE) begin
      chk_vld <= 1'b0;
      if (start) begin
        page_q     <= page;
        n_q        <= n;
        issue_idx  <= '0;
        hit_q      <= 1'b0;
        have_empty <= 1'b0;
        if (CNT_W'(last_slot) < n) begin
          victim_q <= last_slot;
        end else begin
          victim_q <= n_last;
        end
      end
    end else if (state == ST_SCAN) begin
      chk_vld <= issue_go;
      chk_idx <= issue_idx[IDX_W-1:0];
      chk_fv  <= issue_fv;
      if (issue_go) begin
        issue_idx <= issue_idx + CNT_W'(1);
        if (!issue_fv && !have_empty) begin
          have_empty <= 1'b1;
          empty_slot <= issue_idx[IDX_W-1:0];
        end
      end
      if (hit_now) begin
        hit_q    <= 1'b1;
        hit_slot <= chk_idx;
      end
      if (chk_vld && (chk_idx == victim_q)) begin
        ev_cap <= rd_data;
      end
    end else begin
      chk_vld <= 1'b0;
    end
  end

  // Commit the update, register the result and raise done for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done          <= 1'b0;
      last_slot     <= '0;
      fault_counter <= '0;
    end else begin
      done <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        last_slot     <= fin_slot;
        fault_counter <= fault_counter_next;
        fault         <= !hit_q;
        slot          <= slot_ext[SLOT_BITS-1:0];
        evicted_valid <= !hit_q && !have_empty;
        evicted_page  <= (!hit_q && !have_empty) ? ev_cap : '0;
        fault_total   <= fault_counter_next;
      end
    end
  end

endmodule

@@ hw/rtl/mru_page_replacement.sv @@
// Top level of the MRU page replacement block: config register and frame scan.
//
// Usage: drive page and raise start; the reference is taken at an edge where
// start is high and busy is low. busy then stays high while the block scans
// the frames in use, one frame per cycle through a single page comparator fed
// by the frame memory's registered read port.
// Scan: a reference that misses reads all n frames in use, while a hit ends
// the scan at the matching frame. On a miss the chosen frame is written in
// the finish state, from which the result is registered. The next start is
// taken in the result cycle.
// Result: done is high for exactly one cycle with fault, slot, evicted_valid,
// evicted_page and fault_total; the receiver cannot stall it, so it must take
// the beat in that cycle.
// Configuration: the user writes frame_count on the cfg channel (always ready)
// only while the block is idle; the block does not enforce this. Zero acts as
// one frame, values above the built frame count act as the built count.
// Reset: synchronous; all frames empty, MRU frame zero, fault counter zero,
// frame_count four.
module mru_page_replacement #(
  parameter int FRAMES    = mrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = mrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [PAGE_BITS-1:0]             page,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mrupr_pkg::CFG_BITS-1:0]   cfg_data,
  output logic                             done,
  output logic                             fault,
  output logic [mrupr_pkg::SLOT_BITS-1:0]  slot,
  output logic                             evicted_valid,
  output logic [PAGE_BITS-1:0]             evicted_page,
  output logic [mrupr_pkg::COUNT_BITS-1:0] fault_total
);
  import mrupr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  logic [CFG_BITS-1:0]  frame_count;
  logic [CNT_W-1:0]     n_active;
  logic [IDX_W-1:0]     rd_addr;
  logic [PAGE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [PAGE_BITS-1:0] wr_data;
  logic [FRAMES-1:0]    valid_bits;

  assign cfg_ready = 1'b1;

  // Hold the frame count register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_count <= cfg_data;
    end
  end

  // Clamp the frame count to the range that is built
  always_comb begin
    if (frame_count == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frame_count) > FRAMES) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(frame_count);
    end
  end

  mrupr_frame_store #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .valid_bits (valid_bits)
  );

  mrupr_seq #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .page          (page),
    .n             (n_active),
    .busy          (busy),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .valid_bits    (valid_bits),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .done          (done),
    .fault         (fault),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

endmodule

@@ tb/sv/mru_page_replacement_checker.sv @@
// Checker for the MRU page replacement block: tracks frames, predicts and compares results.
module mru_page_replacement_checker #(
  parameter int FRAMES    = mrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = mrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [PAGE_BITS-1:0]             page,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mrupr_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                             done,
  input  logic                             fault,
  input  logic [mrupr_pkg::SLOT_BITS-1:0]  slot,
  input  logic                             evicted_valid,
  input  logic [PAGE_BITS-1:0]             evicted_page,
  input  logic [mrupr_pkg::COUNT_BITS-1:0] fault_total,
  output int                               errors,
  output int                               outstanding
);
  import mrupr_pkg::*;

  // Marks a search that found nothing
  localparam int NO_FRAME = -1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                  fault;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] fault_total;
  } ref_outcome_t;

  // Shadow copy of the block's frame table and registers
  logic [PAGE_BITS-1:0]  frame_page_m [FRAMES];
  logic                  frame_valid_m [FRAMES];
  logic [SLOT_BITS-1:0]  mru_slot_m;
  logic [COUNT_BITS-1:0] fault_count_m;
  logic [CFG_BITS-1:0]   frame_count_m;

  ref_outcome_t expected_outcomes [$];
  int mismatch_count = 0;

  // Resolve one page reference against the shadow frame table
  function automatic ref_outcome_t resolve_reference(logic [PAGE_BITS-1:0] ref_page);
    int in_use;
    int idx;
    int hit_idx;
    int empty_idx;
    ref_outcome_t res;
    if (frame_count_m == 0)
      in_use = 1;
    else if (int'(frame_count_m) > FRAMES)
      in_use = FRAMES;
    else
      in_use = int'(frame_count_m);
    hit_idx = NO_FRAME;
    empty_idx = NO_FRAME;
    for (idx = 0; idx < in_use; idx++) begin
      if (frame_valid_m[idx]) begin
        if (hit_idx == NO_FRAME && frame_page_m[idx] == ref_page) hit_idx = idx;
      end else if (empty_idx == NO_FRAME) begin
        empty_idx = idx;
      end
    end
    res = '0;
    if (hit_idx != NO_FRAME) begin
      res.slot = SLOT_BITS'(hit_idx);
    end else begin
      res.fault = 1'b1;
      if (fault_count_m != COUNT_MAX) fault_count_m = fault_count_m + 1'b1;
      if (empty_idx != NO_FRAME) begin
        res.slot = SLOT_BITS'(empty_idx);
      end else begin
        // MRU frame left beyond a shrunk count: fall back to the top frame in range
        res.slot = (int'(mru_slot_m) < in_use) ? mru_slot_m : SLOT_BITS'(in_use - 1);
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page_m[res.slot];
      end
      frame_page_m[res.slot] = ref_page;
      frame_valid_m[res.slot] = 1'b1;
    end
    mru_slot_m = res.slot;
    res.fault_total = fault_count_m;
    return res;
  endfunction

  // Count a field mismatch; report only the first few
  task automatic check_field(input string field, input logic [COUNT_BITS-1:0] exp_val,
                             input logic [COUNT_BITS-1:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0h, got %0h", field, exp_val, act_val);
    end
  endtask

  // Watch result, config and reference beats at each edge
  always @(posedge clk) begin
    ref_outcome_t exp_res;
    if (rst) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_page_m[i] = '0;
        frame_valid_m[i] = 1'b0;
      end
      mru_slot_m = '0;
      fault_count_m = '0;
      frame_count_m = FRAME_COUNT_RESET;
      expected_outcomes.delete();
    end else begin
      // compare a result beat with the oldest prediction
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected result: slot %0d fault %0b", slot, fault);
        end else begin
          exp_res = expected_outcomes.pop_front();
          check_field("fault", COUNT_BITS'(exp_res.fault), COUNT_BITS'(fault));
          check_field("slot", COUNT_BITS'(exp_res.slot), COUNT_BITS'(slot));
          check_field("evicted_valid", COUNT_BITS'(exp_res.evicted_valid),
                      COUNT_BITS'(evicted_valid));
          check_field("evicted_page", COUNT_BITS'(exp_res.evicted_page),
                      COUNT_BITS'(evicted_page));
          check_field("fault_total", exp_res.fault_total, fault_total);
        end
      end
      // track the frame count register
      if (cfg_valid && cfg_ready) frame_count_m = cfg_data;
      // predict an accepted reference
      if (start && !busy) expected_outcomes.push_back(resolve_reference(page));
    end
    errors <= mismatch_count;
    outstanding <= expected_outcomes.size();
  end

endmodule

@@ tb/sv/mru_page_replacement_tb.sv @@
// Top of the MRU page replacement testbench: clock, reset, stimulus and verdict.
module mru_page_replacement_tb;
  import mrupr_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  localparam int PAGE_BITS = PAGE_BITS_DEF;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 180;
  localparam int POOL_MAX = 32;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [PAGE_BITS-1:0]  page;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  done;
  logic                  fault;
  logic [SLOT_BITS-1:0]  slot;
  logic                  evicted_valid;
  logic [PAGE_BITS-1:0]  evicted_page;
  logic [COUNT_BITS-1:0] fault_total;
  int                    errors;
  int                    outstanding;

  mru_page_replacement #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .page(page),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .fault(fault), .slot(slot), .evicted_valid(evicted_valid),
    .evicted_page(evicted_page), .fault_total(fault_total)
  );

  mru_page_replacement_checker #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .page(page),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .fault(fault), .slot(slot), .evicted_valid(evicted_valid),
    .evicted_page(evicted_page), .fault_total(fault_total),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hand one reference beat to the block, leaving start high
  task automatic send_page(input logic [PAGE_BITS-1:0] value);
    start <= 1'b1;
    page <= value;
    do @(posedge clk); while (busy);
  endtask

  // Drain all results, then write the frame count
  task automatic set_frame_count(input logic [CFG_BITS-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random references in bursts, mostly drawn from a small page pool
  task automatic run_phase(input logic [CFG_BITS-1:0] count_value, input int items);
    logic [PAGE_BITS-1:0] pool [POOL_MAX];
    int in_use;
    int pool_len;
    int sent;
    int burst;
    int gap;
    set_frame_count(count_value);
    if (count_value == 0)
      in_use = 1;
    else if (int'(count_value) > FRAMES)
      in_use = FRAMES;
    else
      in_use = int'(count_value);
    pool_len = $urandom_range(1, in_use + 5);
    for (int i = 0; i < POOL_MAX; i++) pool[i] = PAGE_BITS'($urandom);
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < items; b++) begin
        // refresh a pool entry now and then to break up reuse patterns
        if ($urandom_range(0, 19) == 0)
          pool[$urandom_range(0, pool_len - 1)] = PAGE_BITS'($urandom);
        if ($urandom_range(0, 9) < 7)
          send_page(pool[$urandom_range(0, pool_len - 1)]);
        else
          send_page(PAGE_BITS'($urandom));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] phase_counts [PHASES];
    rst <= 1'b1;
    start <= 1'b0;
    page <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fill four frames, hit, then evict the MRU frame
    set_frame_count(CFG_BITS'(4));
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'hAAAA);
    // shrink while the MRU frame lies beyond the new count
    set_frame_count(CFG_BITS'(2));
    send_page(16'h0F0F);
    send_page(16'h0F0F);
    send_page(16'h0000);
    // zero acts as a single frame
    set_frame_count(CFG_BITS'(0));
    send_page(16'h0000);
    send_page(16'h00FF);
    send_page(16'h00FF);
    // above the built count acts as all frames; hidden frames come back
    set_frame_count(CFG_BITS'(31));
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h8001);
    send_page(16'h8001);
    send_page(16'h7FFE);

    phase_counts[0] = CFG_BITS'(16);
    phase_counts[1] = CFG_BITS'(5);
    phase_counts[2] = CFG_BITS'(1);
    phase_counts[3] = CFG_BITS'(0);
    phase_counts[4] = CFG_BITS'(31);
    phase_counts[5] = CFG_BITS'(17);
    phase_counts[6] = CFG_BITS'(2);
    for (int p = 7; p < PHASES; p++) phase_counts[p] = CFG_BITS'($urandom_range(0, 31));
    for (int p = 0; p < PHASES; p++) run_phase(phase_counts[p], PHASE_ITEMS);

    // drain and let stray results show up
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
